// ===== sv/olst_pkg.sv =====
package olst_pkg;

	// list size and derived widths
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// fixed field widths
	localparam int OP_W     = 3;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;
	localparam int FOUND_W  = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 3'd0,
		OP_DEL_POS = 3'd1,
		OP_DEL_VAL = 3'd2,
		OP_FIND    = 3'd3,
		OP_READ    = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    take;        // request channel ready
		logic    issue;       // read at walk index
		logic    rd_pos;      // read at request position
		logic    cap_rd;      // keep read data as result word
		logic    idx_zero;    // walk index to zero
		logic    idx_pos1;    // walk index to position plus one
		logic    idx_hit1;    // walk index to match plus one
		logic    found_cap;   // keep match index
		logic    app_wr;      // write word at end of list
		logic    cnt_clr;
		logic    cnt_dec;
		logic    shift_wr;    // write back shifted words
		logic    set_status;
		status_t status_code;
		logic    emit;        // load output register
	} olst_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_valid;
		op_t  op;
		logic full;
		logic pos_bad;
		logic hit;
		logic miss;
		logic shift_done;
		logic out_free;
	} olst_stat_t;

endpackage

// ===== sv/olst_req_if.sv =====
interface olst_req_if import olst_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [WORD_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output op, output value, output position, input ready);
	modport sink (input valid, input op, input value, input position, output ready);
endinterface

// ===== sv/olst_rsp_if.sv =====
interface olst_rsp_if import olst_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [FOUND_W-1:0]       found_index;
	logic signed [WORD_W-1:0] read_value;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, output status, output found_index, output read_value,
		output count, input ready);
	modport sink (input valid, input status, input found_index, input read_value,
		input count, output ready);
endinterface

// ===== sv/olst_ram.sv =====
module olst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/olst_datapath.sv =====
module olst_datapath import olst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	olst_req_if.sink    req,
	olst_rsp_if.source  rsp,
	input  olst_cmd_t   cmd,
	output olst_stat_t  st
);

	op_t                      op_q;
	logic [WORD_W-1:0]        value_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         idx_q;
	logic                     rd_vld_s1;
	logic [ADDR_W-1:0]        rd_idx_s1;
	status_t                  res_status_q;
	logic [FOUND_W-1:0]       res_found_q;
	logic [WORD_W-1:0]        res_rd_q;
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic [FOUND_W-1:0]       out_found_q;
	logic [WORD_W-1:0]        out_rd_q;
	logic [COUNT_W-1:0]       out_count_q;

	logic                     accept;
	logic                     issue_ok;
	logic                     rd_en;
	logic [ADDR_W-1:0]        rd_addr;
	logic [WORD_W-1:0]        rd_data;
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	logic [WORD_W-1:0]        wr_data;

	assign accept   = req.valid && cmd.take;
	assign issue_ok = cmd.issue && (idx_q < count_q);

	// memory port selection
	assign rd_en   = issue_ok || cmd.rd_pos;
	assign rd_addr = cmd.rd_pos ? ADDR_W'(pos_q) : idx_q[ADDR_W-1:0];
	assign wr_en   = cmd.app_wr || (cmd.shift_wr && rd_vld_s1);
	assign wr_addr = cmd.app_wr ? count_q[ADDR_W-1:0] : rd_idx_s1 - ADDR_W'(1);
	assign wr_data = cmd.app_wr ? value_q : rd_data;

	olst_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// status toward the controller
	always_comb begin
		st.req_valid  = req.valid;
		st.op         = op_q;
		st.full       = (count_q == CNT_W'(CAPACITY));
		st.pos_bad    = (32'(pos_q) >= 32'(count_q));
		st.hit        = rd_vld_s1 && (rd_data == value_q);
		st.miss       = (idx_q >= count_q) && !rd_vld_s1;
		st.shift_done = (idx_q >= count_q) && !rd_vld_s1;
		st.out_free   = !out_valid_q || rsp.ready;
	end

	// control registers: count, walk index, read pipeline, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.app_wr) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end

			if (cmd.idx_zero) begin
				idx_q <= '0;
			end else if (cmd.idx_pos1) begin
				idx_q <= CNT_W'(pos_q) + CNT_W'(1);
			end else if (cmd.idx_hit1) begin
				idx_q <= CNT_W'(rd_idx_s1) + CNT_W'(1);
			end else if (issue_ok) begin
				idx_q <= idx_q + CNT_W'(1);
			end

			rd_vld_s1 <= issue_ok;

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, result and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(req.op);
			value_q <= req.value;
			pos_q   <= req.position;
		end
		rd_idx_s1 <= idx_q[ADDR_W-1:0];

		if (accept) begin
			res_status_q <= ST_OK;
			res_found_q  <= '0;
			res_rd_q     <= '0;
		end else begin
			if (cmd.set_status) begin
				res_status_q <= cmd.status_code;
			end
			if (cmd.found_cap) begin
				res_found_q <= FOUND_W'(rd_idx_s1);
			end
			if (cmd.cap_rd) begin
				res_rd_q <= rd_data;
			end
		end

		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_rd_q     <= res_rd_q;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	assign req.ready       = cmd.take;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_index = out_found_q;
	assign rsp.read_value  = out_rd_q;
	assign rsp.count       = out_count_q;

endmodule

// ===== sv/olst_ctrl.sv =====
module olst_ctrl import olst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  olst_stat_t st,
	output olst_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_RDWAIT = 6'b000100,
		S_SCAN   = 6'b001000,
		S_SHIFT  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status_code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = 1'b1;
				if (st.req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (st.op) inside
					OP_APPEND: begin
						if (st.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_FULL;
						end else begin
							cmd.app_wr = 1'b1;
						end
					end
					OP_DEL_POS: begin
						if (st.pos_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_RANGE;
						end else begin
							cmd.idx_pos1 = 1'b1;
							state_d      = S_SHIFT;
						end
					end
					OP_DEL_VAL, OP_FIND: begin
						cmd.idx_zero = 1'b1;
						state_d      = S_SCAN;
					end
					OP_READ: begin
						if (st.pos_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_RANGE;
						end else begin
							cmd.rd_pos = 1'b1;
							state_d    = S_RDWAIT;
						end
					end
					OP_CLEAR: begin
						cmd.cnt_clr = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_RDWAIT: begin
				cmd.cap_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_SCAN: begin
				if (st.hit) begin
					cmd.found_cap = 1'b1;
					if (st.op == OP_DEL_VAL) begin
						cmd.idx_hit1 = 1'b1;
						state_d      = S_SHIFT;
					end else begin
						state_d = S_DONE;
					end
				end else if (st.miss) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_MISSING;
					state_d         = S_DONE;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.shift_wr = 1'b1;
				if (st.shift_done) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/ordered_list_store_unit.sv =====
// Ordered list of signed 32-bit words held in one single-port-write,
// registered-read memory of CAPACITY entries.
// Channel req carries op, value and position; channel rsp returns one
// transfer per request with status, found_index, read_value and count.
// Requests are taken one at a time: req.ready is high only while the
// controller waits for work.
// Append, clear, unused codes and rejected requests go straight to the
// result; read at passes through a wait state for the registered memory
// read; find and delete value walk the list from the start until a match
// or the end; delete at position, and delete value on a match, then shift
// every later entry down by one. The walk over the list moves one entry a
// cycle through the memory port; the next request is taken only once the
// previous result is loaded into the output register.
// A result register parts the two sides: the next request is accepted
// while a result waits; when rsp is stalled the block holds its next
// result until the register frees.
// Reset empties the list (count zero) and the memory needs no clearing.
module ordered_list_store_unit import olst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	olst_req_if.sink   req,
	olst_rsp_if.source rsp
);

	olst_cmd_t  cmd;
	olst_stat_t st;

	olst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	olst_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.st     (st)
	);

	// one request in flight at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in work");

	// output register only loaded when free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result overwrote a pending response");

	// append never writes past the end
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.app_wr |-> !st.full)
		else $error("append into a full list");

	// a new result shows up as a valid response next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> rsp.valid)
		else $error("emitted result not presented");

endmodule
